[design/assert_macros.svh]
// Assertion macros shared by the merger RTL.
// Every check is clocked on clock and switched off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define SCUM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// A condition that must be followed by a consequence in the next cycle.
`define SCUM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/scum_pkg.sv]
// Package for the sparse coordinate union merger.
// Holds the token codes, fault codes, queue sizing and the item and result types.
package scum_pkg;

   // Token kind codes.
   localparam logic [1:0] KindData    = 2'd0;
   localparam logic [1:0] KindStop    = 2'd1;
   localparam logic [1:0] KindDone    = 2'd2;

   // Fault codes.
   localparam logic [1:0] FaultNone   = 2'd0;
   localparam logic [1:0] FaultLevel  = 2'd1;
   localparam logic [1:0] FaultKind   = 2'd2;

   // Marker for a stream that has no entry at the emitted coordinate.
   localparam logic [15:0] EmptyRef   = 16'h8000;

   // Request queue between the front and the back part.
   localparam int QDepth = 4;
   localparam int QPtrW  = $clog2(QDepth);
   localparam int QCntW  = $clog2(QDepth + 1);

   // A request as classified by the front part.
   typedef struct packed {
      logic        side;
      logic [1:0]  kind;
      logic [15:0] coord;
      logic [15:0] ref_val;
      logic        is_data;
      logic        is_stop;
      logic        is_done;
   } scum_item_type;

   // One merged result.
   typedef struct packed {
      logic [1:0]  out_kind;
      logic [15:0] out_coord;
      logic        first_ref_present;
      logic [15:0] first_ref;
      logic        second_ref_present;
      logic [15:0] second_ref;
      logic [1:0]  fault;
   } scum_rsp_type;

endpackage

[design/scum_ifs.sv]
// Valid/ready channel interfaces for the merger's request and result sides.
// Depends on nothing; field widths follow the token format.
interface scum_req_if;
   logic        valid;
   logic        ready;
   logic        side;
   logic [1:0]  token_kind;
   logic [15:0] token_coord;
   logic [15:0] token_ref;

   modport source (output valid, output side, output token_kind, output token_coord,
                   output token_ref, input ready);
   modport sink   (input valid, input side, input token_kind, input token_coord,
                   input token_ref, output ready);
endinterface

interface scum_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  out_kind;
   logic [15:0] out_coord;
   logic        first_ref_present;
   logic [15:0] first_ref;
   logic        second_ref_present;
   logic [15:0] second_ref;
   logic [1:0]  fault;

   modport source (output valid, output out_kind, output out_coord,
                   output first_ref_present, output first_ref,
                   output second_ref_present, output second_ref, output fault,
                   input ready);
   modport sink   (input valid, input out_kind, input out_coord,
                   input first_ref_present, input first_ref,
                   input second_ref_present, input second_ref, input fault,
                   output ready);
endinterface

[design/scum_front.sv]
// Front part of the merger: accepts requests, classifies the token kind and
// queues them for the back part. Depends on scum_pkg and scum_req_if.
`include "assert_macros.svh"

module scum_front import scum_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   scum_req_if.sink      req_chan,
   output scum_item_type head_item,
   output logic          head_valid,
   input  logic          head_pop
);

   scum_item_type           q_mem_ff [QDepth];
   logic [QPtrW-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [QPtrW-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [QCntW-1:0]        count_ff, count_in;
   scum_item_type           new_item;
   logic                    push;

   // Classify the incoming token.
   always_comb begin
      new_item.side    = req_chan.side;
      new_item.kind    = req_chan.token_kind;
      new_item.coord   = req_chan.token_coord;
      new_item.ref_val = req_chan.token_ref;
      new_item.is_data = (req_chan.token_kind == KindData);
      new_item.is_stop = (req_chan.token_kind == KindStop);
      new_item.is_done = (req_chan.token_kind == KindDone);
   end

   // A request is taken whenever the queue has a free entry.
   assign req_chan.ready = (count_ff != QCntW'(QDepth));
   assign push           = req_chan.valid && req_chan.ready;
   assign head_valid     = (count_ff != '0);
   assign head_item      = q_mem_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPtrW'(1) : wr_ptr_ff;
      rd_ptr_in = head_pop ? rd_ptr_ff + QPtrW'(1) : rd_ptr_ff;
      count_in  = count_ff + QCntW'(push) - QCntW'(head_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage needs no reset; only entries below the fill count are read.
   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= new_item;
      end
   end

   `SCUM_ASSERT(a_pop_not_empty, !head_pop || head_valid, "pop from an empty request queue")
   `SCUM_ASSERT(a_count_bound, count_ff <= QCntW'(QDepth), "request queue fill count overflow")
   `SCUM_ASSERT_NEXT(a_count_step, push && !head_pop, count_ff == $past(count_ff) + QCntW'(1),
      "request queue count did not advance on push")

endmodule

[design/scum_back.sv]
// Back part of the merger: holds one pending token per stream, pairs them and
// registers one merged result. Depends on scum_pkg and scum_rsp_if.
`include "assert_macros.svh"

module scum_back import scum_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  scum_item_type head_item,
   input  logic          head_valid,
   output logic          head_pop,
   scum_rsp_if.source    rsp_chan
);

   scum_item_type  held_ff [2];
   logic [1:0]     pending_valid_ff, pending_valid_in;
   logic           fault_latched_ff, fault_latched_in;
   scum_rsp_type   rsp_ff;
   logic           rsp_valid_ff, rsp_valid_in;

   scum_item_type  slot0, slot1;
   scum_rsp_type   res;
   logic           take, drop, pair, emit;

   // A queued request is taken when the result register is free or draining.
   assign take     = head_valid && (!rsp_valid_ff || rsp_chan.ready);
   assign head_pop = take;

   // The new token stands in its own slot; the other slot holds its token.
   always_comb begin
      slot0 = head_item.side ? held_ff[0] : head_item;
      slot1 = head_item.side ? head_item  : held_ff[1];
      drop  = fault_latched_ff || pending_valid_ff[head_item.side];
      pair  = !drop && pending_valid_ff[!head_item.side];
   end

   // Pairing decision and slot updates.
   always_comb begin
      res              = '0;
      pending_valid_in = pending_valid_ff;
      fault_latched_in = fault_latched_ff;
      emit             = 1'b0;
      if (take && !drop) begin
         pending_valid_in[head_item.side] = 1'b1;
         if (pair) begin
            emit = 1'b1;
            if (slot0.is_done && slot1.is_done) begin
               res.out_kind           = KindDone;
               res.out_coord          = slot0.coord;
               res.first_ref_present  = 1'b1;
               res.first_ref          = slot0.ref_val;
               res.second_ref_present = 1'b1;
               res.second_ref         = slot1.ref_val;
               pending_valid_in       = 2'b00;
            end else if (slot0.is_stop && slot1.is_data) begin
               res.out_kind           = KindData;
               res.out_coord          = slot1.coord;
               res.second_ref_present = 1'b1;
               res.second_ref         = slot1.ref_val;
               pending_valid_in[1]    = 1'b0;
            end else if (slot0.is_data && slot1.is_stop) begin
               res.out_kind           = KindData;
               res.out_coord          = slot0.coord;
               res.first_ref_present  = 1'b1;
               res.first_ref          = slot0.ref_val;
               pending_valid_in[0]    = 1'b0;
            end else if (slot0.is_stop && slot1.is_stop) begin
               if (slot0.coord != slot1.coord) begin
                  res.fault        = FaultLevel;
                  pending_valid_in = 2'b00;
                  fault_latched_in = 1'b1;
               end else begin
                  res.out_kind           = KindStop;
                  res.out_coord          = slot0.coord;
                  res.first_ref_present  = 1'b1;
                  res.first_ref          = slot0.ref_val;
                  res.second_ref_present = 1'b1;
                  res.second_ref         = slot1.ref_val;
                  pending_valid_in       = 2'b00;
               end
            end else if (slot0.is_data && slot1.is_data) begin
               res.out_kind           = KindData;
               res.first_ref_present  = 1'b1;
               res.second_ref_present = 1'b1;
               if (slot0.coord == slot1.coord) begin
                  res.out_coord    = slot0.coord;
                  res.first_ref    = slot0.ref_val;
                  res.second_ref   = slot1.ref_val;
                  pending_valid_in = 2'b00;
               end else if (slot0.coord > slot1.coord) begin
                  res.out_coord       = slot1.coord;
                  res.first_ref       = EmptyRef;
                  res.second_ref      = slot1.ref_val;
                  pending_valid_in[1] = 1'b0;
               end else begin
                  res.out_coord       = slot0.coord;
                  res.first_ref       = slot0.ref_val;
                  res.second_ref      = EmptyRef;
                  pending_valid_in[0] = 1'b0;
               end
            end else begin
               res.fault        = FaultKind;
               pending_valid_in = 2'b00;
               fault_latched_in = 1'b1;
            end
         end
      end
   end

   // The result register is loaded by a pairing and emptied when taken.
   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_valid_ff <= 2'b00;
         fault_latched_ff <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         pending_valid_ff <= pending_valid_in;
         fault_latched_ff <= fault_latched_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Held tokens and the result payload carry no reset.
   always_ff @(posedge clock) begin
      if (take && !drop) begin
         held_ff[head_item.side] <= head_item;
      end
      if (emit) begin
         rsp_ff <= res;
      end
   end

   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.out_kind           = rsp_ff.out_kind;
   assign rsp_chan.out_coord          = rsp_ff.out_coord;
   assign rsp_chan.first_ref_present  = rsp_ff.first_ref_present;
   assign rsp_chan.first_ref          = rsp_ff.first_ref;
   assign rsp_chan.second_ref_present = rsp_ff.second_ref_present;
   assign rsp_chan.second_ref         = rsp_ff.second_ref;
   assign rsp_chan.fault              = rsp_ff.fault;

   `SCUM_ASSERT_NEXT(a_fault_sticky, fault_latched_ff, fault_latched_ff,
      "latched fault cleared outside reset")
   `SCUM_ASSERT(a_fault_slots_empty, !fault_latched_ff || (pending_valid_ff == 2'b00),
      "a token was held after a fault")
   `SCUM_ASSERT(a_fault_result_clear,
      !rsp_valid_ff || (rsp_ff.fault == FaultNone) ||
      (!rsp_ff.first_ref_present && !rsp_ff.second_ref_present && rsp_ff.out_coord == '0),
      "fault result carries token fields")

endmodule

[design/sparse_coordinate_union_merger_top.sv]
// Top level of the sparse coordinate union merger.
// Depends on scum_pkg, scum_req_if, scum_rsp_if, scum_front and scum_back.
//
// Usage:
//   req_chan carries one token per request: its stream (side), kind (data,
//   stop or done), coordinate or stop level, and reference. rsp_chan carries
//   the merged tokens, at most one for each request, with a reference or an
//   empty marker for each stream and a fault code.
//   A request is accepted in every cycle while the four-entry request queue
//   has room, so while rsp_chan.ready stays high the sustained rate is one
//   request per cycle. The request that completes a pair passes through the
//   queue, then through the pairing logic into the result register.
//   Requests that complete no pair, or that arrive for a stream whose slot is
//   full, produce nothing. After a fault all further requests are consumed
//   silently until reset.
//   When the receiver holds rsp_chan.ready low, the result register holds its
//   result, the back part stops taking from the queue and req_chan.ready
//   falls once the queue is full; nothing is lost.
//   Synchronous reset empties the queue, both stream slots and the result
//   register and clears the fault flag; no clearing pass follows.
module sparse_coordinate_union_merger_top import scum_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   scum_req_if.sink    req_chan,
   scum_rsp_if.source  rsp_chan
);

   scum_item_type head_item;
   logic          head_valid;
   logic          head_pop;

   // Accept and classify requests.
   scum_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .head_item  (head_item),
      .head_valid (head_valid),
      .head_pop   (head_pop)
   );

   // Pair held tokens and produce results.
   scum_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_item  (head_item),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .rsp_chan   (rsp_chan)
   );

endmodule
